// ===== hw/rtl/triangle_area_axis_stats_core_macros.svh =====
// Assertion macros for the triangle area and axis statistics core.
`ifndef TRIANGLE_AREA_AXIS_STATS_CORE_MACROS_SVH
`define TRIANGLE_AREA_AXIS_STATS_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication: when ante holds, cons must hold.
`define TAS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tas assertion failed");
// Next-cycle implication.
`define TAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tas assertion failed");
`else
`define TAS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TAS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/tas_pkg.sv =====
// Shared widths, types and state encodings for the triangle area statistics core.
package tas_pkg;

   localparam int COORD_BITS    = 12;
   localparam int SUM_BITS      = 48;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int PROD_BITS     = 2 * DIFF_BITS;
   localparam int CROSS_BITS    = PROD_BITS + 1;
   localparam int AREA_BITS     = 26;
   localparam int ROOT_BITS     = AREA_BITS + 1;
   localparam int SQ_BITS       = 2 * ROOT_BITS;
   localparam int REM_BITS      = ROOT_BITS + 2;
   localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS);
   localparam int OUT_SUM_BITS  = 48;
   localparam int AXES          = 3;
   localparam int AXIS_BITS     = $clog2(AXES);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [CROSS_BITS-1:0] cross_type;
   typedef logic [CROSS_BITS-1:0]        mag_type;
   typedef logic [AREA_BITS-1:0]         area_type;
   typedef logic [ROOT_BITS-1:0]         root_type;
   typedef logic [SQ_BITS-1:0]           sq_type;
   typedef logic [REM_BITS-1:0]          rem_type;
   typedef logic [SUM_BITS-1:0]          sum_type;
   typedef logic [OUT_SUM_BITS-1:0]      out_sum_type;
   typedef logic [AXES-1:0]              mask_type;
   typedef logic [AXIS_BITS-1:0]         axis_type;

   localparam axis_type AXIS_X = 0;
   localparam axis_type AXIS_Y = 1;
   localparam axis_type AXIS_Z = 2;

   localparam area_type AREA_MAX = '1;

   // One classified triangle, handed from the front to the back.
   typedef struct packed {
      area_type [AXES-1:0] mag;
      logic                sat;
      mask_type            mask;
      logic                first;
   } tri_entry_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_CROSS,
      FRONT_CLASS
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SQUARE,
      BACK_ROOT,
      BACK_UPDATE
   } back_state_type;

endpackage

// ===== hw/rtl/tas_if.sv =====
// Valid/ready channel interfaces for triangle words and statistics results.
interface tas_req_if;
   import tas_pkg::*;

   logic      valid;
   logic      ready;
   coord_type ax;
   coord_type ay;
   coord_type az;
   coord_type bx;
   coord_type by_coord;
   coord_type bz;
   coord_type cx;
   coord_type cy;
   coord_type cz;
   logic      first_of_mesh;

   modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, first_of_mesh,
                   input ready);
   modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, first_of_mesh,
                 output ready);
endinterface

interface tas_rsp_if;
   import tas_pkg::*;

   logic        valid;
   logic        ready;
   area_type    area_twice;
   mask_type    axis_mask;
   out_sum_type total_sum;
   area_type    total_max;
   out_sum_type x_sum;
   out_sum_type y_sum;
   out_sum_type z_sum;
   area_type    x_max;
   area_type    y_max;
   area_type    z_max;

   modport source (output valid, area_twice, axis_mask, total_sum, total_max,
                   x_sum, y_sum, z_sum, x_max, y_max, z_max,
                   input ready);
   modport sink (input valid, area_twice, axis_mask, total_sum, total_max,
                 x_sum, y_sum, z_sum, x_max, y_max, z_max,
                 output ready);
endinterface

// ===== hw/rtl/tas_front.sv =====
// Front end: takes a triangle word, forms the cross product and classifies it.
module tas_front (
   input  logic                   clock,
   input  logic                   reset,
   tas_req_if.sink                req_if,
   output logic                   q_push,
   output tas_pkg::tri_entry_type q_data,
   input  logic                   q_full
);
   import tas_pkg::*;

   front_state_type state_ff, state_in;
   axis_type        step_ff, step_in;
   diff_type        u_ff [AXES];
   diff_type        u_in [AXES];
   diff_type        v_ff [AXES];
   diff_type        v_in [AXES];
   cross_type       n_ff [AXES];
   cross_type       n_in [AXES];
   logic            first_ff, first_in;

   logic      accept;
   diff_type  op_a, op_b, op_c, op_d;
   prod_type  prod_ab, prod_cd;
   cross_type cross_new;
   mag_type   mag [AXES];
   logic      nonzero;
   logic      sat;
   mask_type  mask;

   assign accept = req_if.valid && req_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_IDLE:  if (accept) state_in = FRONT_CROSS;
         FRONT_CROSS: if (step_ff == AXIS_Z) state_in = FRONT_CLASS;
         FRONT_CLASS: if (!q_full) state_in = FRONT_IDLE;
         default:     state_in = FRONT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_if.ready = 1'b0;
      q_push       = 1'b0;
      case (state_ff)
         FRONT_IDLE:  req_if.ready = 1'b1;
         FRONT_CROSS: ;
         FRONT_CLASS: q_push = !q_full;
         default:     ;
      endcase
   end

   // one cross product component per cycle: n_k = u[k+1]*v[k+2] - u[k+2]*v[k+1]
   always_comb begin
      case (step_ff)
         AXIS_X: begin
            op_a = u_ff[AXIS_Y]; op_b = v_ff[AXIS_Z];
            op_c = u_ff[AXIS_Z]; op_d = v_ff[AXIS_Y];
         end
         AXIS_Y: begin
            op_a = u_ff[AXIS_Z]; op_b = v_ff[AXIS_X];
            op_c = u_ff[AXIS_X]; op_d = v_ff[AXIS_Z];
         end
         default: begin
            op_a = u_ff[AXIS_X]; op_b = v_ff[AXIS_Y];
            op_c = u_ff[AXIS_Y]; op_d = v_ff[AXIS_X];
         end
      endcase
      prod_ab   = op_a * op_b;
      prod_cd   = op_c * op_d;
      cross_new = CROSS_BITS'(prod_ab) - CROSS_BITS'(prod_cd);
   end

   always_comb begin
      step_in  = step_ff;
      first_in = first_ff;
      for (int i = 0; i < AXES; i++) begin
         u_in[i] = u_ff[i];
         v_in[i] = v_ff[i];
         n_in[i] = n_ff[i];
      end
      if (accept) begin
         u_in[AXIS_X] = DIFF_BITS'(req_if.bx) - DIFF_BITS'(req_if.ax);
         u_in[AXIS_Y] = DIFF_BITS'(req_if.by_coord) - DIFF_BITS'(req_if.ay);
         u_in[AXIS_Z] = DIFF_BITS'(req_if.bz) - DIFF_BITS'(req_if.az);
         v_in[AXIS_X] = DIFF_BITS'(req_if.cx) - DIFF_BITS'(req_if.ax);
         v_in[AXIS_Y] = DIFF_BITS'(req_if.cy) - DIFF_BITS'(req_if.ay);
         v_in[AXIS_Z] = DIFF_BITS'(req_if.cz) - DIFF_BITS'(req_if.az);
         first_in     = req_if.first_of_mesh;
         step_in      = AXIS_X;
      end
      if (state_ff == FRONT_CROSS) begin
         for (int i = 0; i < AXES; i++) begin
            if (step_ff == AXIS_BITS'(i)) n_in[i] = cross_new;
         end
         step_in = axis_type'(step_ff + 1'b1);
      end
   end

   // classification: magnitudes, dominant axes, area overflow
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         mag[i] = n_ff[i][CROSS_BITS-1] ? $unsigned(-n_ff[i]) : $unsigned(n_ff[i]);
      end
      nonzero = (mag[AXIS_X] != '0) || (mag[AXIS_Y] != '0) || (mag[AXIS_Z] != '0);
      mask[AXIS_X] = nonzero && (mag[AXIS_X] >= mag[AXIS_Y]) && (mag[AXIS_X] >= mag[AXIS_Z]);
      mask[AXIS_Y] = nonzero && (mag[AXIS_Y] >= mag[AXIS_Z]) && (mag[AXIS_Y] >= mag[AXIS_X]);
      mask[AXIS_Z] = nonzero && (mag[AXIS_Z] >= mag[AXIS_X]) && (mag[AXIS_Z] >= mag[AXIS_Y]);
      sat = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         if ((mag[i] >> AREA_BITS) != '0) sat = 1'b1;
         q_data.mag[i] = AREA_BITS'(mag[i]);
      end
      q_data.sat   = sat;
      q_data.mask  = mask;
      q_data.first = first_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      first_ff <= first_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      n_ff     <= n_in;
   end

endmodule

// ===== hw/rtl/tas_queue.sv =====
// Short queue between the front and back ends.
module tas_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tas_pkg::tri_entry_type push_data,
   output logic                   full,
   input  logic                   pop,
   output tas_pkg::tri_entry_type pop_data,
   output logic                   empty
);
   import tas_pkg::*;

   tri_entry_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]     count_ff, count_in;

   function automatic logic [QPTR_BITS-1:0] ptr_next(input logic [QPTR_BITS-1:0] p);
      if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) return '0;
      return QPTR_BITS'(p + 1'b1);
   endfunction

   assign full     = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = QCNT_BITS'(count_ff + 1'b1);
      if (pop && !push) count_in = QCNT_BITS'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== hw/rtl/tas_back.sv =====
// Back end: sum of squares, digit-by-digit square root, accumulator update.
module tas_back (
   input  logic                   clock,
   input  logic                   reset,
   input  tas_pkg::tri_entry_type q_data,
   input  logic                   q_empty,
   output logic                   q_pop,
   tas_rsp_if.source              rsp_if
);
   import tas_pkg::*;

   back_state_type            state_ff, state_in;
   tri_entry_type             ent_ff, ent_in;
   axis_type                  sq_idx_ff, sq_idx_in;
   sq_type                    sq_acc_ff, sq_acc_in;
   sq_type                    rad_ff, rad_in;
   rem_type                   rem_ff, rem_in;
   root_type                  root_ff, root_in;
   logic [ROOT_CNT_BITS-1:0]  cnt_ff, cnt_in;

   sum_type   sum_all_ff, sum_all_in;
   area_type  max_all_ff, max_all_in;
   sum_type   sum_axis_ff [AXES];
   sum_type   sum_axis_in [AXES];
   area_type  max_axis_ff [AXES];
   area_type  max_axis_in [AXES];
   logic      rsp_valid_ff, rsp_valid_in;
   area_type  area_ff, area_in;
   mask_type  mask_ff, mask_in;

   logic                     out_free;
   logic                     upd_fire;
   area_type                 sq_op;
   logic [2*AREA_BITS-1:0]   sq_prod;
   rem_type                  rem_sh;
   rem_type                  trial;
   logic                     ge;
   area_type                 area;
   sum_type                  base_sum;
   area_type                 base_max;

   function automatic sum_type sat_add(input sum_type a, input area_type b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + (SUM_BITS + 1)'(b);
      return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
   endfunction

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE:   if (!q_empty) state_in = BACK_SQUARE;
         BACK_SQUARE: if (sq_idx_ff == AXIS_Z) state_in = BACK_ROOT;
         BACK_ROOT:   if (cnt_ff == '0) state_in = BACK_UPDATE;
         BACK_UPDATE: if (out_free) state_in = BACK_IDLE;
         default:     state_in = BACK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop    = 1'b0;
      upd_fire = 1'b0;
      case (state_ff)
         BACK_IDLE:   q_pop = !q_empty;
         BACK_SQUARE: ;
         BACK_ROOT:   ;
         BACK_UPDATE: upd_fire = out_free;
         default:     ;
      endcase
   end

   // datapath
   always_comb begin
      sq_op   = ent_ff.mag[sq_idx_ff];
      sq_prod = sq_op * sq_op;
      rem_sh  = {rem_ff[ROOT_BITS-1:0], rad_ff[SQ_BITS-1 -: 2]};
      trial   = {root_ff, 2'b01};
      ge      = (rem_sh >= trial);
      area    = (ent_ff.sat || root_ff[ROOT_BITS-1]) ? AREA_MAX : root_ff[AREA_BITS-1:0];

      ent_in    = ent_ff;
      sq_idx_in = sq_idx_ff;
      sq_acc_in = sq_acc_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;

      case (state_ff)
         BACK_IDLE: begin
            ent_in    = q_data;
            sq_idx_in = AXIS_X;
            sq_acc_in = '0;
         end
         BACK_SQUARE: begin
            sq_acc_in = sq_acc_ff + SQ_BITS'(sq_prod);
            sq_idx_in = axis_type'(sq_idx_ff + 1'b1);
            rad_in    = sq_acc_in;
            rem_in    = '0;
            root_in   = '0;
            cnt_in    = ROOT_CNT_BITS'(ROOT_BITS - 1);
         end
         BACK_ROOT: begin
            // two radicand bits enter per step, one root bit leaves
            rem_in  = ge ? rem_type'(rem_sh - trial) : rem_sh;
            root_in = {root_ff[ROOT_BITS-2:0], ge};
            rad_in  = rad_ff << 2;
            cnt_in  = ROOT_CNT_BITS'(cnt_ff - 1'b1);
         end
         default: ;
      endcase
   end

   // accumulators and result register
   always_comb begin
      sum_all_in   = sum_all_ff;
      max_all_in   = max_all_ff;
      sum_axis_in  = sum_axis_ff;
      max_axis_in  = max_axis_ff;
      area_in      = area_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (upd_fire) begin
         base_sum   = ent_ff.first ? '0 : sum_all_ff;
         base_max   = ent_ff.first ? '0 : max_all_ff;
         sum_all_in = sat_add(base_sum, area);
         max_all_in = (area > base_max) ? area : base_max;
         for (int i = 0; i < AXES; i++) begin
            base_sum = ent_ff.first ? '0 : sum_axis_ff[i];
            base_max = ent_ff.first ? '0 : max_axis_ff[i];
            sum_axis_in[i] = base_sum;
            max_axis_in[i] = base_max;
            if (ent_ff.mask[i]) begin
               sum_axis_in[i] = sat_add(base_sum, area);
               max_axis_in[i] = (area > base_max) ? area : base_max;
            end
         end
         area_in      = area;
         mask_in      = ent_ff.mask;
         rsp_valid_in = 1'b1;
      end else begin
         base_sum = '0;
         base_max = '0;
      end
   end

   // statistics registers only change on reset or when a result is loaded into rsp
   always_comb begin
      rsp_if.valid      = rsp_valid_ff;
      rsp_if.area_twice = area_ff;
      rsp_if.axis_mask  = mask_ff;
      rsp_if.total_sum  = OUT_SUM_BITS'(sum_all_ff);
      rsp_if.total_max  = max_all_ff;
      rsp_if.x_sum      = OUT_SUM_BITS'(sum_axis_ff[AXIS_X]);
      rsp_if.y_sum      = OUT_SUM_BITS'(sum_axis_ff[AXIS_Y]);
      rsp_if.z_sum      = OUT_SUM_BITS'(sum_axis_ff[AXIS_Z]);
      rsp_if.x_max      = max_axis_ff[AXIS_X];
      rsp_if.y_max      = max_axis_ff[AXIS_Y];
      rsp_if.z_max      = max_axis_ff[AXIS_Z];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_all_ff   <= '0;
         max_all_ff   <= '0;
         for (int i = 0; i < AXES; i++) begin
            sum_axis_ff[i] <= '0;
            max_axis_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_all_ff   <= sum_all_in;
         max_all_ff   <= max_all_in;
         sum_axis_ff  <= sum_axis_in;
         max_axis_ff  <= max_axis_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff    <= ent_in;
      sq_idx_ff <= sq_idx_in;
      sq_acc_ff <= sq_acc_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      cnt_ff    <= cnt_in;
      area_ff   <= area_in;
      mask_ff   <= mask_in;
   end

endmodule

// ===== hw/rtl/triangle_area_axis_stats_core.sv =====
// Top level of the triangle area and dominant normal axis statistics core.
// Each req word carries one triangle. The front end forms the edge vectors
// and the cross product and drops the classified triangle into a two-entry
// queue; the back end then picks it up, sums the three squared cross product
// components on one 26x26 multiplier, runs the bit-per-step square root and
// finally updates the statistics and loads the rsp register. Sustained
// throughput is set by the square root in the back end, which takes no new
// triangle from the queue until it has loaded the last one's result. The
// front keeps taking words while the queue has room, and a finished result
// may wait in the rsp register while the next triangle is worked on. A word
// with first_of_mesh set clears all sums and maxima before its own area is
// added.
`include "triangle_area_axis_stats_core_macros.svh"

module triangle_area_axis_stats_core (
   input logic       clock,
   input logic       reset,
   tas_req_if.sink   req_if,
   tas_rsp_if.source rsp_if
);
   import tas_pkg::*;

   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;
   tri_entry_type q_push_data;
   tri_entry_type q_pop_data;
   logic          rsp_mask_ok;
   logic          rsp_max_ok;

   tas_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_push (q_push),
      .q_data (q_push_data),
      .q_full (q_full)
   );

   tas_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   tas_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_data  (q_pop_data),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

   // zero area exactly when no axis dominates; every max bounded by the total max
   assign rsp_mask_ok = ((rsp_if.axis_mask == '0) == (rsp_if.area_twice == '0));
   assign rsp_max_ok  = (rsp_if.area_twice <= rsp_if.total_max)
                     && (rsp_if.x_max <= rsp_if.total_max)
                     && (rsp_if.y_max <= rsp_if.total_max)
                     && (rsp_if.z_max <= rsp_if.total_max);

   `TAS_ASSERT_IMPL(a_queue_no_overflow, clock, reset, q_push, !q_full)
   `TAS_ASSERT_NEXT(a_single_pop, clock, reset, q_pop, !q_pop)
   `TAS_ASSERT_IMPL(a_mask_iff_area, clock, reset, rsp_if.valid, rsp_mask_ok)
   `TAS_ASSERT_IMPL(a_max_bounds, clock, reset, rsp_if.valid, rsp_max_ok)

endmodule

// ===== sim/tas_stats_checker.sv =====
// Channel monitor for the triangle area core: predicts each rsp word and compares it.
module tas_stats_checker (
   input  logic clock,
   input  logic reset,
   tas_req_if   req_mon,
   tas_rsp_if   rsp_mon,
   output int   mismatches,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import tas_pkg::*;

   typedef struct {
      area_type    area_twice;
      mask_type    axis_mask;
      out_sum_type total_sum;
      area_type    total_max;
      out_sum_type axis_sum [AXES];
      area_type    axis_max [AXES];
   } tri_stats_type;

   localparam longint unsigned AREA_CAP = (64'd1 << AREA_BITS) - 1;
   localparam longint unsigned SUM_CAP  =
      (SUM_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : (64'd1 << SUM_BITS) - 1;

   // running mesh statistics as the block should hold them
   longint unsigned mesh_sum;
   longint unsigned mesh_max;
   longint unsigned axis_sum_acc [AXES];
   longint unsigned axis_max_acc [AXES];

   tri_stats_type expected_stats_q [$];
   int            results_checked;

   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         longint unsigned t;
         t = r | (64'd1 << b);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   function automatic longint unsigned sat_add(input longint unsigned acc,
                                               input longint unsigned add);
      if (acc > SUM_CAP || add > SUM_CAP - acc) return SUM_CAP;
      return acc + add;
   endfunction

   function automatic void clear_mesh_stats();
      mesh_sum = 0;
      mesh_max = 0;
      for (int i = 0; i < AXES; i++) begin
         axis_sum_acc[i] = 0;
         axis_max_acc[i] = 0;
      end
   endfunction

   function automatic tri_stats_type predict_triangle_stats(input longint signed pa [3],
                                                            input longint signed pb [3],
                                                            input longint signed pc [3],
                                                            input logic first);
      longint signed   u [3];
      longint signed   v [3];
      longint signed   n [3];
      longint unsigned mag [3];
      longint unsigned area;
      mask_type        mask;
      tri_stats_type   r;
      for (int i = 0; i < AXES; i++) begin
         u[i] = pb[i] - pa[i];
         v[i] = pc[i] - pa[i];
      end
      n[AXIS_X] = u[AXIS_Y] * v[AXIS_Z] - u[AXIS_Z] * v[AXIS_Y];
      n[AXIS_Y] = u[AXIS_Z] * v[AXIS_X] - u[AXIS_X] * v[AXIS_Z];
      n[AXIS_Z] = u[AXIS_X] * v[AXIS_Y] - u[AXIS_Y] * v[AXIS_X];
      for (int i = 0; i < AXES; i++)
         mag[i] = (n[i] < 0) ? longint'(-n[i]) : longint'(n[i]);

      if (mag[AXIS_X] > AREA_CAP || mag[AXIS_Y] > AREA_CAP || mag[AXIS_Z] > AREA_CAP) begin
         area = AREA_CAP;
      end else begin
         area = floor_sqrt(mag[AXIS_X] * mag[AXIS_X] + mag[AXIS_Y] * mag[AXIS_Y]
                           + mag[AXIS_Z] * mag[AXIS_Z]);
         if (area > AREA_CAP) area = AREA_CAP;
      end

      // degenerate triangle: no dominant axis at all
      mask = '0;
      if ((mag[AXIS_X] | mag[AXIS_Y] | mag[AXIS_Z]) != 0) begin
         mask[AXIS_X] = (mag[AXIS_X] >= mag[AXIS_Y]) && (mag[AXIS_X] >= mag[AXIS_Z]);
         mask[AXIS_Y] = (mag[AXIS_Y] >= mag[AXIS_X]) && (mag[AXIS_Y] >= mag[AXIS_Z]);
         mask[AXIS_Z] = (mag[AXIS_Z] >= mag[AXIS_X]) && (mag[AXIS_Z] >= mag[AXIS_Y]);
      end

      if (first) clear_mesh_stats();
      mesh_sum = sat_add(mesh_sum, area);
      if (area > mesh_max) mesh_max = area;
      for (int i = 0; i < AXES; i++) begin
         if (mask[i]) begin
            axis_sum_acc[i] = sat_add(axis_sum_acc[i], area);
            if (area > axis_max_acc[i]) axis_max_acc[i] = area;
         end
      end

      r.area_twice = area[AREA_BITS-1:0];
      r.axis_mask  = mask;
      r.total_sum  = mesh_sum[OUT_SUM_BITS-1:0];
      r.total_max  = mesh_max[AREA_BITS-1:0];
      for (int i = 0; i < AXES; i++) begin
         r.axis_sum[i] = axis_sum_acc[i][OUT_SUM_BITS-1:0];
         r.axis_max[i] = axis_max_acc[i][AREA_BITS-1:0];
      end
      return r;
   endfunction

   function automatic void compare_field(input int idx, input string name,
                                         input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         if (mismatches < 10)
            $display("rsp word %0d: %s expected %0d, got %0d", idx, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      longint signed pa [3];
      longint signed pb [3];
      longint signed pc [3];
      tri_stats_type want;
      if (reset) begin
         clear_mesh_stats();
         expected_stats_q.delete();
         results_checked = 0;
         mismatches = 0;
         pending <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_stats_q.size() == 0) begin
               if (mismatches < 10)
                  $display("rsp word %0d arrived with no triangle outstanding", results_checked);
               mismatches++;
            end else begin
               want = expected_stats_q.pop_front();
               compare_field(results_checked, "area_twice", 64'(want.area_twice),
                             64'(rsp_mon.area_twice));
               compare_field(results_checked, "axis_mask", 64'(want.axis_mask),
                             64'(rsp_mon.axis_mask));
               compare_field(results_checked, "total_sum", 64'(want.total_sum),
                             64'(rsp_mon.total_sum));
               compare_field(results_checked, "total_max", 64'(want.total_max),
                             64'(rsp_mon.total_max));
               compare_field(results_checked, "x_sum", 64'(want.axis_sum[AXIS_X]),
                             64'(rsp_mon.x_sum));
               compare_field(results_checked, "y_sum", 64'(want.axis_sum[AXIS_Y]),
                             64'(rsp_mon.y_sum));
               compare_field(results_checked, "z_sum", 64'(want.axis_sum[AXIS_Z]),
                             64'(rsp_mon.z_sum));
               compare_field(results_checked, "x_max", 64'(want.axis_max[AXIS_X]),
                             64'(rsp_mon.x_max));
               compare_field(results_checked, "y_max", 64'(want.axis_max[AXIS_Y]),
                             64'(rsp_mon.y_max));
               compare_field(results_checked, "z_max", 64'(want.axis_max[AXIS_Z]),
                             64'(rsp_mon.z_max));
            end
            results_checked++;
         end
         if (req_mon.valid && req_mon.ready) begin
            pa[AXIS_X] = longint'(req_mon.ax);
            pa[AXIS_Y] = longint'(req_mon.ay);
            pa[AXIS_Z] = longint'(req_mon.az);
            pb[AXIS_X] = longint'(req_mon.bx);
            pb[AXIS_Y] = longint'(req_mon.by_coord);
            pb[AXIS_Z] = longint'(req_mon.bz);
            pc[AXIS_X] = longint'(req_mon.cx);
            pc[AXIS_Y] = longint'(req_mon.cy);
            pc[AXIS_Z] = longint'(req_mon.cz);
            expected_stats_q.push_back(
               predict_triangle_stats(pa, pb, pc, req_mon.first_of_mesh));
         end
         pending <= expected_stats_q.size();
      end
   end

endmodule

// ===== sim/tb_triangle_area_axis_stats_core.sv =====
// Testbench top for the triangle area and axis statistics core: stimulus and verdict.
module tb_triangle_area_axis_stats_core;
   timeunit 1ns;
   timeprecision 1ps;
   import tas_pkg::*;

   localparam int RANDOM_WORDS = 750;
   localparam int IDLE_LIMIT   = 5000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      int   a [3];
      int   b [3];
      int   c [3];
      logic first;
   } tri_word_type;

   typedef enum int {RSP_OPEN, RSP_MOSTLY, RSP_SPARSE, RSP_PERIODIC} rsp_mode_type;

   logic clock = 1'b0;
   logic reset;

   int fail_count;
   int pending_results;
   int words_sent;
   int degenerate_built;
   int mesh_restarts;
   int results_seen;
   int long_holds;
   int idle_cycles;

   tas_req_if req_if ();
   tas_rsp_if rsp_if ();

   triangle_area_axis_stats_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   tas_stats_checker stats_chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .mismatches (fail_count),
      .pending    (pending_results)
   );

   always #2 clock = ~clock;

   function automatic tri_word_type make_tri(input int ax, input int ay, input int az,
                                             input int bx, input int by, input int bz,
                                             input int cx, input int cy, input int cz,
                                             input logic first);
      tri_word_type w;
      w.a[AXIS_X] = ax;  w.a[AXIS_Y] = ay;  w.a[AXIS_Z] = az;
      w.b[AXIS_X] = bx;  w.b[AXIS_Y] = by;  w.b[AXIS_Z] = bz;
      w.c[AXIS_X] = cx;  w.c[AXIS_Y] = cy;  w.c[AXIS_Z] = cz;
      w.first = first;
      return w;
   endfunction

   function automatic int rand_coord();
      coord_type c;
      c = coord_type'($urandom);
      return int'(c);
   endfunction

   function automatic int rand_span(input int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   // mostly full-range triangles; the rest small, collinear, planar or tied normals
   function automatic tri_word_type random_tri();
      tri_word_type w;
      int           kind, rot, m, p, q;
      int           base [3];
      int           u [3];
      int           v [3];
      kind = $urandom_range(0, 99);
      w.first = ($urandom_range(0, 24) == 0);
      if (kind < 65) begin
         for (int i = 0; i < 3; i++) begin
            w.a[i] = rand_coord();
            w.b[i] = rand_coord();
            w.c[i] = rand_coord();
         end
         return w;
      end
      for (int i = 0; i < 3; i++) base[i] = rand_span(1000);
      rot = $urandom_range(0, 2);
      if (kind < 75) begin
         for (int i = 0; i < 3; i++) begin
            u[i] = rand_span(4);
            v[i] = rand_span(4);
         end
      end else if (kind < 85) begin
         m = rand_span(2);
         for (int i = 0; i < 3; i++) begin
            u[i] = rand_span(300);
            v[i] = m * u[i];
         end
         degenerate_built++;
      end else if (kind < 93) begin
         u[0] = rand_span(900);  u[1] = rand_span(900);  u[2] = 0;
         v[0] = rand_span(900);  v[1] = rand_span(900);  v[2] = 0;
      end else if ($urandom_range(0, 1) == 0) begin
         // two equal normal components
         p = rand_span(900);
         q = rand_span(900);
         u[0] = 0;  u[1] = 0;   u[2] = p;
         v[0] = q;  v[1] = -q;  v[2] = 0;
      end else begin
         // all three components equal in magnitude
         p = rand_span(900);
         u[0] = p;  u[1] = p;  u[2] = 0;
         v[0] = p;  v[1] = 0;  v[2] = p;
      end
      for (int i = 0; i < 3; i++) begin
         w.a[(i + rot) % 3] = base[(i + rot) % 3];
         w.b[(i + rot) % 3] = base[(i + rot) % 3] + u[i];
         w.c[(i + rot) % 3] = base[(i + rot) % 3] + v[i];
      end
      return w;
   endfunction

   task automatic send_word(input tri_word_type w);
      req_if.valid         <= 1'b1;
      req_if.ax            <= coord_type'(w.a[AXIS_X]);
      req_if.ay            <= coord_type'(w.a[AXIS_Y]);
      req_if.az            <= coord_type'(w.a[AXIS_Z]);
      req_if.bx            <= coord_type'(w.b[AXIS_X]);
      req_if.by_coord      <= coord_type'(w.b[AXIS_Y]);
      req_if.bz            <= coord_type'(w.b[AXIS_Z]);
      req_if.cx            <= coord_type'(w.c[AXIS_X]);
      req_if.cy            <= coord_type'(w.c[AXIS_Y]);
      req_if.cz            <= coord_type'(w.c[AXIS_Z]);
      req_if.first_of_mesh <= w.first;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
      if (w.first) mesh_restarts++;
   endtask

   // pending is registered after the handshake, so the task steps the clock before it first looks
   task automatic wait_for_results();
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int n, burst, gap;
      bit paused;
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.ax            <= '0;
      req_if.ay            <= '0;
      req_if.az            <= '0;
      req_if.bx            <= '0;
      req_if.by_coord      <= '0;
      req_if.bz            <= '0;
      req_if.cx            <= '0;
      req_if.cy            <= '0;
      req_if.cz            <= '0;
      req_if.first_of_mesh <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // corners, coincident and collinear points, single axes and ties
      send_word(make_tri(-2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048, 0));
      send_word(make_tri(2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 1));
      send_word(make_tri(-2048, -2048, -2048, 2047, -2048, -2048, -2048, 2047, -2048, 0));
      send_word(make_tri(-2048, -2048, -2048, 2047, 2047, -2048, 2047, -2048, 2047, 0));
      send_word(make_tri(2047, 2047, 2047, -2048, -2048, 2047, -2048, 2047, -2048, 0));
      send_word(make_tri(0, 0, 0, 1, 2, 3, 2, 4, 6, 0));
      send_word(make_tri(5, 5, 5, 5, 5, 6, 6, 4, 5, 0));
      send_word(make_tri(0, 0, 0, 1, 0, 0, 1, 1, -1, 0));
      send_word(make_tri(0, 0, 0, 0, 1, 0, 1, 0, -1, 0));
      send_word(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
      send_word(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0, 0));
      send_word(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1));
      send_word(make_tri(-2048, -2048, -2048, -2048, 2047, -2048, -2048, -2048, 2047, 0));
      send_word(make_tri(2047, 2047, 2047, 2047, 2047, -2048, -2048, 2047, 2047, 0));
      send_word(make_tri(2047, -2048, 2047, -2048, 2047, -2048, 2047, 2047, -2048, 0));
      send_word(make_tri(-2048, 2047, 0, 2047, -2048, 0, 0, 0, 2047, 0));
      send_word(make_tri(0, 0, 0, 1, 2, 0, 0, 1, 2, 0));
      degenerate_built += 3;
      req_if.valid <= 1'b0;
      wait_for_results();

      n = 0;
      paused = 0;
      while (n < RANDOM_WORDS) begin
         burst = $urandom_range(1, 16);
         for (int k = 0; k < burst && n < RANDOM_WORDS; k++) begin
            send_word(random_tri());
            n++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         if (!paused && n >= RANDOM_WORDS / 2) begin
            paused = 1;
            req_if.valid <= 1'b0;
            wait_for_results();
         end
      end
      req_if.valid <= 1'b0;
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d triangles (%0d built degenerate), %0d mesh restarts",
               words_sent, degenerate_built, mesh_restarts);
      $display("checked %0d rsp words, %0d long rsp hold-offs, %0d mismatches",
               results_seen, long_holds, fail_count);
      if (fail_count == 0 && pending_results == 0) begin
         $display("[triangle_area_axis_stats_core] OK");
      end else begin
         $display("[triangle_area_axis_stats_core] ERROR");
      end
      $finish;
   end

   initial begin : rsp_side
      rsp_mode_type mode;
      int           seg, period, hold_mark;
      rsp_if.ready <= 1'b0;
      hold_mark = 200;
      forever begin
         mode   = rsp_mode_type'($urandom_range(0, 3));
         seg    = $urandom_range(20, 200);
         period = $urandom_range(2, 5);
         for (int k = 0; k < seg; k++) begin
            @(posedge clock);
            if (rsp_if.valid && rsp_if.ready) results_seen++;
            if (results_seen >= hold_mark) begin
               // long hold-off: the core fills up and must stall req
               rsp_if.ready <= 1'b0;
               long_holds++;
               hold_mark = (hold_mark == 200) ? 550 : 32'h7FFF_FFFF;
               repeat (LONG_HOLD) @(posedge clock);
            end else begin
               case (mode)
                  RSP_OPEN:     rsp_if.ready <= 1'b1;
                  RSP_MOSTLY:   rsp_if.ready <= ($urandom_range(0, 3) != 0);
                  RSP_SPARSE:   rsp_if.ready <= ($urandom_range(0, 3) == 0);
                  RSP_PERIODIC: rsp_if.ready <= (k % period == 0);
                  default:      rsp_if.ready <= 1'b1;
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("no word moved for %0d cycles, %0d results outstanding",
                  idle_cycles, pending_results);
         $display("[triangle_area_axis_stats_core] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tas_pkg.sv
hw/rtl/tas_if.sv
hw/rtl/tas_front.sv
hw/rtl/tas_queue.sv
hw/rtl/tas_back.sv
hw/rtl/triangle_area_axis_stats_core.sv
sim/tas_stats_checker.sv
sim/tb_triangle_area_axis_stats_core.sv
